// ===== rtl/core/bat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the block allocation table.
// No dependencies; used by the table unit.
package bat_pkg;

    localparam int TABLE_BLOCKS = 1024;
    localparam int BLOCK_BYTES  = 64;
    localparam int IDX_W        = $clog2(TABLE_BLOCKS);
    localparam int BLK_W        = 10;
    localparam int CNT_W        = 11;
    localparam int SIZE_W       = 16;
    localparam int ID_W         = 5;
    localparam int TAG_W        = 8;

    typedef enum logic [1:0] {
        CMD_RESERVE    = 2'd0,
        CMD_FREE       = 2'd1,
        CMD_FREE_OWNER = 2'd2,
        CMD_RSVD       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NEG    = 3'd1,
        ST_RANGE  = 3'd2,
        ST_UNUSED = 3'd3,
        ST_DENIED = 3'd4
    } t_status;

    typedef struct packed {
        logic            used;
        logic            shared;
        logic            last;
        logic [ID_W-1:0] owner;
    } t_tag;

endpackage

// ===== rtl/core/block_allocation_table_unit.sv =====
`timescale 1ns / 1ps
// Block allocation table with owner tags: command sequencer around one tag RAM.
// Depends on bat_pkg and bat_ram.
//
// Usage:
//   Command channel: a command is taken at a rising edge with start high and busy
//   low. Fields: i_cmd, i_block_index, i_size_bytes, i_shared, i_owner_id,
//   i_requester_id. Every command returns one result transaction: o_status,
//   o_first_block, o_blocks_changed, marked by o_done for exactly one cycle.
//   There is no result back-pressure; the receiver must take it in that cycle.
//   i_cfg_we / i_cfg_wdata write kernel_id; write it only while busy is low.
// Command flow:
//   rejected reserve, zero-size reserve, unknown command: answered from idle.
//   free of an unused block or without permission: ends after the entry check.
//   reserve: one tag RAM write per cycle, one per block.
//   free: walks back to the chunk start, then forward over the chunk, clearing it.
//   free all of owner: scans the whole table and frees each matching chunk the same way.
//   All walks go through the single RAM read port, one entry per cycle.
// Reset: busy stays high while the tag RAM is cleared one entry per cycle;
// kernel_id returns to 0.
module block_allocation_table_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [bat_pkg::ID_W-1:0]       i_cfg_wdata,
    input  logic [1:0]                     i_cmd,
    input  logic [bat_pkg::BLK_W-1:0]      i_block_index,
    input  logic signed [bat_pkg::SIZE_W-1:0] i_size_bytes,
    input  logic                           i_shared,
    input  logic [bat_pkg::ID_W-1:0]       i_owner_id,
    input  logic [bat_pkg::ID_W-1:0]       i_requester_id,
    output logic                           o_done,
    output logic [2:0]                     o_status,
    output logic [bat_pkg::BLK_W-1:0]      o_first_block,
    output logic [bat_pkg::CNT_W-1:0]      o_blocks_changed
);
    import bat_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RES, S_CHK, S_BACK, S_FWD, S_SCAN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_BLOCKS - 1);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [BLK_W-1:0]  r_first, n_first;
    logic              r_shared, n_shared;
    logic [ID_W-1:0]   r_owner, n_owner;
    logic [ID_W-1:0]   r_req, n_req;
    logic              r_scan, n_scan;
    logic              r_any, n_any;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_kernel;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [TAG_W-1:0]  w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    logic [TAG_W-1:0]  w_rdata;
    t_tag              w_tag;
    logic              w_permit;
    logic              w_at_end;
    logic              w_at_zero;
    logic              w_fin;
    logic [SIZE_W-1:0] w_sum;
    logic [CNT_W-1:0]  w_blocks;
    logic [IDX_W+1:0]  w_end;

    bat_ram #(
        .WIDTH(TAG_W),
        .DEPTH(TABLE_BLOCKS)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_tag     = t_tag'(w_rdata);
    assign w_permit  = w_tag.shared || (w_tag.owner == r_req) || (r_req == r_kernel);
    assign w_at_end  = (r_ptr == LAST_IDX);
    assign w_at_zero = (r_ptr == '0);
    assign w_fin     = !w_tag.used || w_tag.last || w_at_end;

    assign w_sum    = {1'b0, i_size_bytes[SIZE_W-2:0]} + SIZE_W'(BLOCK_BYTES - 1);
    assign w_blocks = CNT_W'(w_sum / BLOCK_BYTES);
    assign w_end    = (IDX_W+2)'(i_block_index) + (IDX_W+2)'(w_blocks);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_rem    = r_rem;
        n_total  = r_total;
        n_first  = r_first;
        n_shared = r_shared;
        n_owner  = r_owner;
        n_req    = r_req;
        n_scan   = r_scan;
        n_any    = r_any;
        n_done   = 1'b0;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_ptr;
        w_wdata  = '0;
        w_raddr  = r_ptr;

        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (w_at_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_shared = i_shared;
                    n_owner  = i_owner_id;
                    n_req    = i_requester_id;
                    n_any    = 1'b0;
                    n_scan   = 1'b0;
                    n_first  = i_block_index;
                    n_total  = '0;
                    n_ptr    = IDX_W'(i_block_index);
                    unique case (t_cmd'(i_cmd))
                        CMD_RESERVE: begin
                            if (i_size_bytes[SIZE_W-1]) begin
                                n_done   = 1'b1;
                                n_status = ST_NEG;
                            end else if (w_end > (IDX_W+2)'(TABLE_BLOCKS)) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end else if (w_blocks == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_rem   = w_blocks;
                                n_total = w_blocks;
                                n_state = S_RES;
                            end
                        end
                        CMD_FREE: begin
                            w_raddr = IDX_W'(i_block_index);
                            n_state = S_CHK;
                        end
                        CMD_FREE_OWNER: begin
                            n_scan  = 1'b1;
                            n_ptr   = '0;
                            n_first = '0;
                            w_raddr = '0;
                            n_state = S_SCAN;
                        end
                        CMD_RSVD: begin
                            n_first  = '0;
                            n_done   = 1'b1;
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RES: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, r_shared, (r_rem == CNT_W'(1)), r_owner};
                n_ptr   = r_ptr + 1'b1;
                n_rem   = r_rem - 1'b1;
                if (r_rem == CNT_W'(1)) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            S_CHK: begin
                if (!w_tag.used) begin
                    n_done   = 1'b1;
                    n_status = ST_UNUSED;
                    n_state  = S_IDLE;
                end else if (!w_permit) begin
                    n_done   = 1'b1;
                    n_status = ST_DENIED;
                    n_state  = S_IDLE;
                end else if (w_at_zero) begin
                    w_raddr = '0;
                    n_any   = 1'b1;
                    if (!r_any) n_first = '0;
                    n_state = S_FWD;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    w_raddr = r_ptr - 1'b1;
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                n_any   = 1'b1;
                n_state = S_FWD;
                if (w_tag.used && !w_tag.last) begin
                    if (w_at_zero) begin
                        w_raddr = '0;
                        if (!r_any) n_first = '0;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        w_raddr = r_ptr - 1'b1;
                        n_any   = r_any;
                        n_state = S_BACK;
                    end
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    w_raddr = r_ptr + 1'b1;
                    if (!r_any) n_first = BLK_W'(r_ptr + 1'b1);
                end
            end
            S_FWD: begin
                w_raddr = r_ptr + 1'b1;
                if (w_tag.used) begin
                    w_we    = 1'b1;
                    n_total = r_total + 1'b1;
                end
                if (w_fin && (!r_scan || w_at_end)) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    if (w_fin) n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tag.used && (w_tag.owner == r_owner) && w_permit) begin
                    if (w_at_zero) begin
                        w_raddr = '0;
                        n_any   = 1'b1;
                        if (!r_any) n_first = '0;
                        n_state = S_FWD;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        w_raddr = r_ptr - 1'b1;
                        n_state = S_BACK;
                    end
                end else if (w_at_end) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    w_raddr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_done   <= 1'b0;
            r_kernel <= '0;
            r_status <= ST_OK;
            r_any    <= 1'b0;
            r_scan   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_done   <= n_done;
            r_status <= n_status;
            r_any    <= n_any;
            r_scan   <= n_scan;
            if (i_cfg_we) begin
                r_kernel <= i_cfg_wdata;
            end
        end
        r_rem    <= n_rem;
        r_total  <= n_total;
        r_first  <= n_first;
        r_shared <= n_shared;
        r_owner  <= n_owner;
        r_req    <= n_req;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_first_block    = r_first;
    assign o_blocks_changed = r_total;

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a command is still in progress");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command neither started nor completed");

    a_error_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != 3'(ST_OK))) |-> (o_blocks_changed == '0))
        else $error("rejected command reports changed blocks");

endmodule

// ===== rtl/core/bat_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
